// ===== rtl/b64sd_pkg.sv =====
// Shared types, codes and the character table for the base64 stream decoder.
`default_nettype none
package b64sd_pkg;

   localparam int unsigned MAX_SYMBOLS_DEFAULT = 65536;
   localparam logic [15:0] CAP_RESET           = 16'd49152;
   localparam int unsigned QUEUE_DEPTH         = 2;

   // Status codes reported on the final result
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_INVALID   = 2'd1;
   localparam logic [1:0] ST_TOO_SMALL = 2'd2;

   typedef enum logic [2:0] {
      CLS_DATA = 3'd0,
      CLS_PAD  = 3'd1,
      CLS_CR   = 3'd2,
      CLS_LF   = 3'd3,
      CLS_BAD  = 3'd4
   } cls_type;

   typedef struct packed {
      cls_type    cls;
      logic [5:0] value;
      logic       last;
   } entry_type;

   // Map one raw character to its class and six-bit value
   function automatic entry_type classify(input logic [7:0] c, input logic last);
      entry_type e;
      e.last  = last;
      e.value = 6'd0;
      e.cls   = CLS_BAD;
      case (c) inside
         [8'h41:8'h5A]: begin
            e.cls   = CLS_DATA;
            e.value = 6'(c - 8'h41);
         end
         [8'h61:8'h7A]: begin
            e.cls   = CLS_DATA;
            e.value = 6'(c - 8'h61 + 8'd26);
         end
         [8'h30:8'h39]: begin
            e.cls   = CLS_DATA;
            e.value = 6'(c - 8'h30 + 8'd52);
         end
         8'h2B: begin
            e.cls   = CLS_DATA;
            e.value = 6'd62;
         end
         8'h2F: begin
            e.cls   = CLS_DATA;
            e.value = 6'd63;
         end
         8'h3D: e.cls = CLS_PAD;
         8'h0D: e.cls = CLS_CR;
         8'h0A: e.cls = CLS_LF;
         default: e.cls = CLS_BAD;
      endcase
      return e;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/b64sd_front.sv =====
// Front end: takes characters off the input channel and classifies them for the queue.
`default_nettype none
module b64sd_front (
   input  wire logic                  req_valid,
   input  wire logic [7:0]            req_symbol,
   input  wire logic                  req_last,
   output logic                       req_stall,
   input  wire logic                  q_full,
   output logic                       q_push,
   output b64sd_pkg::entry_type       q_entry
);

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign q_entry   = b64sd_pkg::classify(req_symbol, req_last);

endmodule
`default_nettype wire

// ===== rtl/b64sd_queue.sv =====
// Two-entry queue between the classifier and the decode back end.
`default_nettype none
module b64sd_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire b64sd_pkg::entry_type  push_entry,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       head_valid,
   output b64sd_pkg::entry_type       head_entry
);

   localparam int unsigned PW = (b64sd_pkg::QUEUE_DEPTH > 1) ?
                                $clog2(b64sd_pkg::QUEUE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(b64sd_pkg::QUEUE_DEPTH + 1);

   b64sd_pkg::entry_type slot_ff [b64sd_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full       = (count_ff == CW'(b64sd_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      if (p == PW'(b64sd_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PW'(1);
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(b64sd_pkg::QUEUE_DEPTH))
      else $error("queue count above depth");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + CW'(1))
      else $error("queue count did not grow on push");
   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      do_pop && !do_push |=> count_ff == $past(count_ff) - CW'(1))
      else $error("queue count did not shrink on pop");

endmodule
`default_nettype wire

// ===== rtl/b64sd_back.sv =====
// Back end: group assembly, error tracking, length accounting and the result register.
`default_nettype none
module b64sd_back #(
   parameter int unsigned MAX_SYMBOLS = b64sd_pkg::MAX_SYMBOLS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [15:0]           csr_wr_data,
   input  wire logic                  q_valid,
   input  wire b64sd_pkg::entry_type  q_entry,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [7:0]                 rsp_first_byte,
   output logic [7:0]                 rsp_second_byte,
   output logic [7:0]                 rsp_third_byte,
   output logic [1:0]                 rsp_byte_count,
   output logic [1:0]                 rsp_status,
   output logic [15:0]                rsp_total_length,
   output logic                       rsp_final_res
);

   localparam int unsigned SCW = $clog2(MAX_SYMBOLS + 1);
   localparam int unsigned CW  = (SCW > 16) ? SCW : 16;

   logic [15:0]    cap_ff;
   logic [23:0]    acc_ff,  acc_in;
   logic [1:0]     fill_ff, fill_in;
   logic [1:0]     pad_ff,  pad_in;
   logic [SCW-1:0] sc_ff,   sc_in;
   logic [SCW-1:0] need_ff, need_in;
   logic [15:0]    bw_ff,   bw_in;
   logic           err_ff,  err_in;
   logic           pcr_ff,  pcr_in;

   logic           rsp_valid_ff;
   logic [7:0]     b0_ff, b0_in, b1_ff, b1_in, b2_ff, b2_in;
   logic [1:0]     cnt_ff, cnt_in, st_ff, st_in;
   logic [15:0]    tot_ff, tot_in;
   logic           fin_ff;

   logic           out_ready, fire;
   logic [16:0]    bw_sum;
   logic [CW-1:0]  need_w;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign fire      = q_valid && out_ready;
   assign q_pop     = out_ready;

   always_comb begin
      acc_in  = acc_ff;
      fill_in = fill_ff;
      pad_in  = pad_ff;
      sc_in   = sc_ff;
      need_in = need_ff;
      bw_in   = bw_ff;
      err_in  = err_ff;
      pcr_in  = pcr_ff;
      b0_in   = 8'd0;
      b1_in   = 8'd0;
      b2_in   = 8'd0;
      cnt_in  = 2'd0;
      st_in   = b64sd_pkg::ST_OK;
      tot_in  = 16'd0;
      bw_sum  = 17'd0;
      need_w  = '0;

      if (!err_ff) begin
         if (pcr_ff) begin
            pcr_in = 1'b0;
            if (q_entry.cls != b64sd_pkg::CLS_LF) err_in = 1'b1;
         end else if (q_entry.cls == b64sd_pkg::CLS_CR) begin
            pcr_in = 1'b1;
         end else if (q_entry.cls != b64sd_pkg::CLS_LF) begin
            if (q_entry.cls == b64sd_pkg::CLS_BAD) begin
               err_in = 1'b1;
            end else if (q_entry.cls == b64sd_pkg::CLS_PAD) begin
               if (pad_ff == 2'd2) err_in = 1'b1;
               else pad_in = pad_ff + 2'd1;
            end else if (pad_ff != 2'd0) begin
               err_in = 1'b1;
            end
            if (!err_in) begin
               if (sc_ff == SCW'(MAX_SYMBOLS)) begin
                  err_in = 1'b1;
               end else begin
                  sc_in  = sc_ff + SCW'(1);
                  acc_in = {acc_ff[17:0], q_entry.value};
                  // required length grows on three of every four symbols, pads take one back
                  need_in = need_ff + SCW'(fill_ff != 2'd3)
                            - SCW'(q_entry.cls == b64sd_pkg::CLS_PAD);
                  if (fill_ff == 2'd3) begin
                     fill_in = 2'd0;
                     cnt_in  = 2'd3 - pad_in;
                     b0_in   = acc_in[23:16];
                     if (cnt_in > 2'd1) b1_in = acc_in[15:8];
                     if (cnt_in > 2'd2) b2_in = acc_in[7:0];
                     bw_sum = {1'b0, bw_ff} + 17'(cnt_in);
                     bw_in  = bw_sum[16] ? 16'hFFFF : bw_sum[15:0];
                  end else begin
                     fill_in = fill_ff + 2'd1;
                  end
               end
            end
         end
      end

      if (q_entry.last) begin
         need_w = CW'(need_in);
         if (err_in || pcr_in) begin
            st_in = b64sd_pkg::ST_INVALID;
         end else if (need_w > CW'(cap_ff)) begin
            st_in  = b64sd_pkg::ST_TOO_SMALL;
            tot_in = (need_w > CW'(16'hFFFF)) ? 16'hFFFF : need_w[15:0];
         end else begin
            tot_in = bw_in;
         end
         // drop all message state for the next message
         acc_in  = '0;
         fill_in = '0;
         pad_in  = '0;
         sc_in   = '0;
         need_in = '0;
         bw_in   = '0;
         err_in  = 1'b0;
         pcr_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= b64sd_pkg::CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         fill_ff <= '0;
         pad_ff  <= '0;
         sc_ff   <= '0;
         need_ff <= '0;
         bw_ff   <= '0;
         err_ff  <= 1'b0;
         pcr_ff  <= 1'b0;
      end else if (fire) begin
         acc_ff  <= acc_in;
         fill_ff <= fill_in;
         pad_ff  <= pad_in;
         sc_ff   <= sc_in;
         need_ff <= need_in;
         bw_ff   <= bw_in;
         err_ff  <= err_in;
         pcr_ff  <= pcr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         b0_ff  <= b0_in;
         b1_ff  <= b1_in;
         b2_ff  <= b2_in;
         cnt_ff <= cnt_in;
         st_ff  <= st_in;
         tot_ff <= tot_in;
         fin_ff <= q_entry.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_first_byte   = b0_ff;
   assign rsp_second_byte  = b1_ff;
   assign rsp_third_byte   = b2_ff;
   assign rsp_byte_count   = cnt_ff;
   assign rsp_status       = st_ff;
   assign rsp_total_length = tot_ff;
   assign rsp_final_res    = fin_ff;

   a_fill_tracks_count: assert property (@(posedge clock) disable iff (reset)
      fill_ff == sc_ff[1:0])
      else $error("group fill out of step with symbol count");
   a_status_only_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !fin_ff |-> st_ff == b64sd_pkg::ST_OK && tot_ff == 16'd0)
      else $error("status or length on a non-final result");
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      fire && q_entry.last |=> sc_ff == '0 && !err_ff && !pcr_ff && bw_ff == 16'd0)
      else $error("message state not cleared after last");
   a_no_bytes_in_error: assert property (@(posedge clock) disable iff (reset)
      fire && err_ff |=> cnt_ff == 2'd0)
      else $error("bytes emitted after an error");

endmodule
`default_nettype wire

// ===== rtl/base64_stream_decoder.sv =====
// A transferred character is written into the queue, then decoded into the result
// register. Throughput: one character per cycle unless a stall holds it; the result
// register advances whenever it is empty or being taken, and a two-entry queue
// absorbs a stall on either side. Reset: synchronous, active high; clears all
// message state and the queue, and sets cap_ff to 49152. No clearing pass.
`default_nettype none
module base64_stream_decoder #(
   parameter int unsigned MAX_SYMBOLS = b64sd_pkg::MAX_SYMBOLS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_symbol,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_first_byte,
   output logic [7:0]       rsp_second_byte,
   output logic [7:0]       rsp_third_byte,
   output logic [1:0]       rsp_byte_count,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_total_length,
   output logic             rsp_final_res
);

   logic                 q_full, q_push, q_pop, q_head_valid;
   b64sd_pkg::entry_type q_push_entry, q_head_entry;

   b64sd_front u_front (
      .req_valid  (req_valid),
      .req_symbol (req_symbol),
      .req_last   (req_last),
      .req_stall  (req_stall),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_push_entry)
   );

   b64sd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry)
   );

   b64sd_back #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .q_valid          (q_head_valid),
      .q_entry          (q_head_entry),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_first_byte   (rsp_first_byte),
      .rsp_second_byte  (rsp_second_byte),
      .rsp_third_byte   (rsp_third_byte),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_status       (rsp_status),
      .rsp_total_length (rsp_total_length),
      .rsp_final_res    (rsp_final_res)
   );

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for base64_stream_decoder: directed messages, then random streams.
`timescale 1ns / 100ps
module tb;

   localparam int unsigned SYM_PAD        = 64;
   localparam int unsigned SYM_BAD        = 127;
   localparam logic [7:0]  CH_CR          = 8'h0D;
   localparam logic [7:0]  CH_LF          = 8'h0A;
   localparam logic [7:0]  CH_PAD         = 8'h3D;
   localparam int unsigned SETTLE_CYCLES  = 6;
   // worst quiet stretch: a send gap, a response stall, pipeline and a capacity write
   localparam int unsigned WATCHDOG_LIMIT = 200;
   localparam int unsigned PHASE_ITEMS    = 56;
   localparam int          DIR_ROWS       = 11;

   typedef struct packed {
      logic [7:0]  first_byte;
      logic [7:0]  second_byte;
      logic [7:0]  third_byte;
      logic [1:0]  byte_count;
      logic [1:0]  status;
      logic [15:0] total_length;
      logic        final_res;
   } decode_out_type;

   typedef struct packed {
      logic           typed;
      logic [15:0]    capacity;
      decode_out_type want;
   } dir_row_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_valid   = 1'b0;
   logic [7:0]  req_symbol  = '0;
   logic        req_last    = 1'b0;
   logic        rsp_stall   = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [7:0]  rsp_first_byte;
   logic [7:0]  rsp_second_byte;
   logic [7:0]  rsp_third_byte;
   logic [1:0]  rsp_byte_count;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_total_length;
   logic        rsp_final_res;

   // decoder state as the block should hold it
   logic [15:0] capacity_now = b64sd_pkg::CAP_RESET;
   logic [23:0] grp_acc      = '0;
   int unsigned grp_fill     = 0;
   int unsigned pad_seen     = 0;
   int unsigned sym_total    = 0;
   int unsigned bytes_out    = 0;
   bit          bad_input    = 1'b0;
   bit          cr_waiting   = 1'b0;

   decode_out_type decode_backlog [$];
   logic [7:0]  msg_chars [$];
   int unsigned mismatches    = 0;
   int unsigned results_seen  = 0;
   int unsigned send_pct      = 50;
   int unsigned take_pct      = 50;
   string       b64_alphabet  =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   // octal escapes: \015 is CR, \012 is LF, \301 is a byte above 127
   string dir_text [DIR_ROWS] = '{"TWFu", "////", "+A\015\012==", "\012", "*", "\301",
                                  "===", "A=A", "\015A", "\015", "TQ=="};
   dir_row_type dir_rows [DIR_ROWS] = '{
      '{1'b1, b64sd_pkg::CAP_RESET,
        '{8'h4D, 8'h61, 8'h6E, 2'd3, b64sd_pkg::ST_OK, 16'd3, 1'b1}},
      '{1'b1, b64sd_pkg::CAP_RESET,
        '{8'hFF, 8'hFF, 8'hFF, 2'd3, b64sd_pkg::ST_OK, 16'd3, 1'b1}},
      '{1'b0, b64sd_pkg::CAP_RESET, '0},
      '{1'b1, b64sd_pkg::CAP_RESET,
        '{8'h00, 8'h00, 8'h00, 2'd0, b64sd_pkg::ST_OK, 16'd0, 1'b1}},
      '{1'b1, b64sd_pkg::CAP_RESET,
        '{8'h00, 8'h00, 8'h00, 2'd0, b64sd_pkg::ST_INVALID, 16'd0, 1'b1}},
      '{1'b1, b64sd_pkg::CAP_RESET,
        '{8'h00, 8'h00, 8'h00, 2'd0, b64sd_pkg::ST_INVALID, 16'd0, 1'b1}},
      '{1'b1, b64sd_pkg::CAP_RESET,
        '{8'h00, 8'h00, 8'h00, 2'd0, b64sd_pkg::ST_INVALID, 16'd0, 1'b1}},
      '{1'b1, b64sd_pkg::CAP_RESET,
        '{8'h00, 8'h00, 8'h00, 2'd0, b64sd_pkg::ST_INVALID, 16'd0, 1'b1}},
      '{1'b1, b64sd_pkg::CAP_RESET,
        '{8'h00, 8'h00, 8'h00, 2'd0, b64sd_pkg::ST_INVALID, 16'd0, 1'b1}},
      '{1'b1, b64sd_pkg::CAP_RESET,
        '{8'h00, 8'h00, 8'h00, 2'd0, b64sd_pkg::ST_INVALID, 16'd0, 1'b1}},
      '{1'b1, 16'd0,
        '{8'h4D, 8'h00, 8'h00, 2'd1, b64sd_pkg::ST_TOO_SMALL, 16'd1, 1'b1}}
   };

   base64_stream_decoder uut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_symbol       (req_symbol),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_first_byte   (rsp_first_byte),
      .rsp_second_byte  (rsp_second_byte),
      .rsp_third_byte   (rsp_third_byte),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_status       (rsp_status),
      .rsp_total_length (rsp_total_length),
      .rsp_final_res    (rsp_final_res)
   );

   always #6 clock = ~clock;

   function automatic int unsigned symbol_value(input logic [7:0] c);
      if (c >= "A" && c <= "Z") return int'(c - "A");
      if (c >= "a" && c <= "z") return int'(c - "a") + 26;
      if (c >= "0" && c <= "9") return int'(c - "0") + 52;
      if (c == "+") return 62;
      if (c == "/") return 63;
      if (c == CH_PAD) return SYM_PAD;
      return SYM_BAD;
   endfunction

   function automatic int unsigned draw_wait(input int unsigned pct);
      return ($urandom_range(0, 99) < pct) ? $urandom_range(0, 7) : 0;
   endfunction

   function automatic logic [7:0] pick_data_char();
      return b64_alphabet[$urandom_range(0, 63)];
   endfunction

   function automatic logic [7:0] pick_noise();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return CH_PAD;
         4: return CH_CR;
         5: return pick_data_char();
         6: return "*";
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Advance the decoder state by one character and give the result it causes.
   task automatic decode_char(input logic [7:0] c, input logic fin,
                              output decode_out_type r);
      int unsigned v;
      int unsigned need;
      r = '0;
      if (!bad_input) begin
         if (cr_waiting) begin
            cr_waiting = 1'b0;
            if (c != CH_LF) bad_input = 1'b1;
         end else if (c == CH_CR) begin
            cr_waiting = 1'b1;
         end else if (c != CH_LF) begin
            v = symbol_value(c);
            if (v == SYM_BAD) begin
               bad_input = 1'b1;
            end else if (v == SYM_PAD) begin
               if (pad_seen >= 2) bad_input = 1'b1;
               else pad_seen++;
            end else if (pad_seen != 0) begin
               bad_input = 1'b1;
            end
            if (!bad_input) begin
               if (sym_total >= b64sd_pkg::MAX_SYMBOLS_DEFAULT) begin
                  bad_input = 1'b1;
               end else begin
                  sym_total++;
                  // a pad shifts in zero bits
                  grp_acc = {grp_acc[17:0], 6'(v)};
                  if (grp_fill == 3) begin
                     grp_fill = 0;
                     r.byte_count = 2'(3 - pad_seen);
                     r.first_byte = grp_acc[23:16];
                     if (r.byte_count > 1) r.second_byte = grp_acc[15:8];
                     if (r.byte_count > 2) r.third_byte = grp_acc[7:0];
                     bytes_out += r.byte_count;
                     if (bytes_out > 65535) bytes_out = 65535;
                  end else begin
                     grp_fill++;
                  end
               end
            end
         end
      end
      if (fin) begin
         if (cr_waiting) bad_input = 1'b1;
         r.final_res = 1'b1;
         if (bad_input) begin
            r.status = b64sd_pkg::ST_INVALID;
         end else if (sym_total != 0) begin
            need = (sym_total * 6 + 7) / 8;
            need = (need > pad_seen) ? need - pad_seen : 0;
            if (need > capacity_now) begin
               r.status       = b64sd_pkg::ST_TOO_SMALL;
               r.total_length = (need > 65535) ? 16'hFFFF : 16'(need);
            end else begin
               r.total_length = 16'(bytes_out);
            end
         end
         grp_acc    = '0;
         grp_fill   = 0;
         pad_seen   = 0;
         sym_total  = 0;
         bytes_out  = 0;
         bad_input  = 1'b0;
         cr_waiting = 1'b0;
      end
   endtask

   task automatic report(input string msg);
      mismatches++;
      if (mismatches <= 40) $display("ERROR %0t result %0d: %s", $time, results_seen, msg);
   endtask

   task automatic compare_field(input string name, input int unsigned got,
                                input int unsigned want);
      if (got != want) report($sformatf("%s is %0h, should be %0h", name, got, want));
   endtask

   task automatic check_result(input decode_out_type got);
      decode_out_type want;
      if (decode_backlog.size() == 0) begin
         report($sformatf("result %h with no character outstanding", got));
      end else begin
         want = decode_backlog.pop_front();
         compare_field("first_byte", got.first_byte, want.first_byte);
         compare_field("second_byte", got.second_byte, want.second_byte);
         compare_field("third_byte", got.third_byte, want.third_byte);
         compare_field("byte_count", got.byte_count, want.byte_count);
         compare_field("status", got.status, want.status);
         compare_field("total_length", got.total_length, want.total_length);
         compare_field("final_res", got.final_res, want.final_res);
      end
   endtask

   task automatic send_char(input logic [7:0] sym, input logic fin, input bit typed,
                            input decode_out_type want);
      int unsigned gap;
      decode_out_type due;
      gap = draw_wait(send_pct);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_symbol <= sym;
      req_last   <= fin;
      do @(posedge clock); while (req_stall);
      decode_char(sym, fin, due);
      decode_backlog.push_back(typed ? want : due);
   endtask

   // Send msg_chars as one message; a typed result replaces the prediction on its last character.
   task automatic send_message(input bit typed, input decode_out_type want);
      int unsigned i;
      for (i = 0; i < msg_chars.size(); i++)
         send_char(msg_chars[i], i == msg_chars.size() - 1,
                   typed && (i == msg_chars.size() - 1), want);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (decode_backlog.size() != 0);
   endtask

   task automatic set_capacity(input logic [15:0] value);
      req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      capacity_now = value;
   endtask

   // Mostly well-formed messages with random content; some get one stray byte.
   task automatic build_message();
      int unsigned groups, pads, n, i, at;
      logic [7:0] stray;
      msg_chars.delete();
      groups = $urandom_range(0, 6);
      pads   = (groups != 0) ? $urandom_range(0, 2) : 0;
      n      = groups * 4;
      for (i = 0; i < n; i++) begin
         msg_chars.push_back((i >= n - pads) ? CH_PAD : pick_data_char());
         if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1) != 0) msg_chars.push_back(CH_CR);
            msg_chars.push_back(CH_LF);
         end
      end
      // leave a trailing group incomplete now and then
      if (pads == 0 && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) msg_chars.push_back(pick_data_char());
      if ($urandom_range(0, 4) == 0) begin
         stray = pick_noise();
         at    = $urandom_range(0, msg_chars.size());
         if (at == msg_chars.size()) msg_chars.push_back(stray);
         else msg_chars.insert(at, stray);
      end
      if (msg_chars.size() == 0) msg_chars.push_back(CH_LF);
   endtask

   initial begin : rsp_side
      int unsigned hold;
      decode_out_type got;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got = '{rsp_first_byte, rsp_second_byte, rsp_third_byte, rsp_byte_count,
                    rsp_status, rsp_total_length, rsp_final_res};
            check_result(got);
            results_seen++;
            hold = draw_wait(take_pct);
         end else if (hold != 0) begin
            hold--;
         end
         rsp_stall <= (hold != 0);
      end
   end

   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      @(negedge reset);
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("tb failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned r, i, ph, sent;
      logic [15:0] cap;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (r = 0; r < DIR_ROWS; r++) begin
         if (dir_rows[r].capacity != capacity_now) set_capacity(dir_rows[r].capacity);
         msg_chars.delete();
         for (i = 0; i < dir_text[r].len(); i++) msg_chars.push_back(dir_text[r][i]);
         send_message(dir_rows[r].typed, dir_rows[r].want);
      end

      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0: cap = 16'hFFFF;
            1: cap = 16'd0;
            2: cap = 16'd1;
            5: cap = 16'($urandom_range(0, 65535));
            default: cap = 16'($urandom_range(0, 24));
         endcase
         set_capacity(cap);
         send_pct = (ph % 3) * 50;
         take_pct = ((ph + 1) % 3) * 50;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            build_message();
            sent += msg_chars.size();
            send_message(1'b0, '0);
            // hold off until the decoder has emptied
            if ($urandom_range(0, 5) == 0) begin
               req_valid <= 1'b0;
               wait_drained();
            end
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("tb passed");
      else $display("tb failed");
      $finish;
   end
endmodule
